/* rtl/srcc_pkg.sv */
`default_nettype none
package srcc_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int MAX_ENTRIES = 65536;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int ENT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = ENT_W + 1;
    localparam int CS_W  = $clog2(MAX_COLUMNS + 1);
    localparam int SWEEP = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int SWP_W = $clog2(SWEEP + 1);

    localparam int ACT_W  = 3;
    localparam int CFG_W  = 13;
    localparam int RIDX_W = 16;
    localparam int VAL_W  = 64;
    localparam int CIDX_W = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BUILD = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RPTR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RSLOT = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_COL   = 3'd1;
    localparam logic [2:0] ST_BAD_ROW   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_BUILT = 3'd4;
    localparam logic [2:0] ST_BAD_IDX   = 3'd5;
    localparam logic [2:0] ST_BUILT     = 3'd6;

    localparam logic [CIDX_W-1:0] CFG_NCOLS  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NROWS  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_OFFSET = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_ent;

    typedef struct packed {
        logic             latch;
        logic             eval;
        logic             clr_store;
        logic             clr_wr;
        logic             ld_rd;
        logic             ld_wr;
        logic             pfx_init;
        logic             pfx_rd;
        logic             pfx_end;
        logic             rs_rd_ent;
        logic             rs_rd_nxt;
        logic             rs_wr;
        logic             cs_rd_tmp;
        logic             cs_rd_nxt;
        logic             cs_wr;
        logic             ptr_rd;
        logic             slot_rd;
        logic             set_built;
        logic             emit;
        logic [SWP_W-1:0] k;
        logic [ENT_W-1:0] i;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             ok;
        logic             out_free;
        logic [CNT_W-1:0] stored;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/srcc_ctrl.sv */
`default_nettype none
module srcc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire srcc_pkg::t_stat i_stat,
    output srcc_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_LDW   = 4'd3;
    localparam logic [3:0] S_PFX   = 4'd4;
    localparam logic [3:0] S_PFXE  = 4'd5;
    localparam logic [3:0] S_RS    = 4'd6;
    localparam logic [3:0] S_CS    = 4'd7;
    localparam logic [3:0] S_BDONE = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]                 r_state, n_state;
    logic [srcc_pkg::SWP_W-1:0] r_k, n_k;
    logic [srcc_pkg::ENT_W-1:0] r_i, n_i;
    logic [1:0]                 r_ph, n_ph;
    logic                       r_pend, n_pend;
    logic                       last;

    assign last = (srcc_pkg::CNT_W'({1'b0, r_i}) + srcc_pkg::CNT_W'(1)) == i_stat.stored;

    always_comb begin
        o_cmd      = '0;
        o_cmd.k    = r_k;
        o_cmd.i    = r_i;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_k        = r_k;
        n_i        = r_i;
        n_ph       = r_ph;
        n_pend     = r_pend;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                n_k = r_k + srcc_pkg::SWP_W'(1);
                if (r_k == srcc_pkg::SWP_W'(srcc_pkg::SWEEP - 1)) begin
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.eval = 1'b1;
                n_state    = S_FIN;
                unique case (i_stat.act)
                    srcc_pkg::ACT_CLEAR: begin
                        o_cmd.clr_store = 1'b1;
                        n_k     = '0;
                        n_pend  = 1'b1;
                        n_state = S_CLR;
                    end
                    srcc_pkg::ACT_LOAD: begin
                        if (i_stat.ok) begin
                            o_cmd.ld_rd = 1'b1;
                            n_state     = S_LDW;
                        end
                    end
                    srcc_pkg::ACT_BUILD: begin
                        o_cmd.pfx_init = 1'b1;
                        n_k     = '0;
                        n_state = S_PFX;
                    end
                    srcc_pkg::ACT_RPTR:  o_cmd.ptr_rd  = i_stat.ok;
                    srcc_pkg::ACT_RSLOT: o_cmd.slot_rd = i_stat.ok;
                    default: n_state = S_FIN;
                endcase
            end
            S_LDW: begin
                o_cmd.ld_wr = 1'b1;
                n_state     = S_FIN;
            end
            S_PFX: begin
                if (r_k != srcc_pkg::SWP_W'(srcc_pkg::SWEEP)) begin
                    o_cmd.pfx_rd = 1'b1;
                    n_k = r_k + srcc_pkg::SWP_W'(1);
                end else begin
                    n_state = S_PFXE;
                end
            end
            S_PFXE: begin
                o_cmd.pfx_end = 1'b1;
                n_i  = '0;
                n_ph = 2'd0;
                n_state = (i_stat.stored == '0) ? S_BDONE : S_RS;
            end
            S_RS: begin
                case (r_ph)
                    2'd0: begin
                        o_cmd.rs_rd_ent = 1'b1;
                        n_ph = 2'd1;
                    end
                    2'd1: begin
                        o_cmd.rs_rd_nxt = 1'b1;
                        n_ph = 2'd2;
                    end
                    default: begin
                        o_cmd.rs_wr = 1'b1;
                        n_ph = 2'd0;
                        if (last) begin
                            n_i     = '0;
                            n_state = S_CS;
                        end else begin
                            n_i = r_i + srcc_pkg::ENT_W'(1);
                        end
                    end
                endcase
            end
            S_CS: begin
                case (r_ph)
                    2'd0: begin
                        o_cmd.cs_rd_tmp = 1'b1;
                        n_ph = 2'd1;
                    end
                    2'd1: begin
                        o_cmd.cs_rd_nxt = 1'b1;
                        n_ph = 2'd2;
                    end
                    default: begin
                        o_cmd.cs_wr = 1'b1;
                        n_ph = 2'd0;
                        if (last) begin
                            n_i     = '0;
                            n_state = S_BDONE;
                        end else begin
                            n_i = r_i + srcc_pkg::ENT_W'(1);
                        end
                    end
                endcase
            end
            S_BDONE: begin
                o_cmd.set_built = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_k     <= '0;
            r_i     <= '0;
            r_ph    <= 2'd0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_ph    <= n_ph;
            r_pend  <= n_pend;
        end
    end

endmodule
`default_nettype wire

/* rtl/srcc_dp.sv */
`default_nettype none
module srcc_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srcc_pkg::t_cmd                i_cmd,
    output srcc_pkg::t_stat                    o_stat,
    input  wire logic [srcc_pkg::ACT_W-1:0]    i_action,
    input  wire logic [srcc_pkg::ROW_W-1:0]    i_row_index,
    input  wire logic [srcc_pkg::CFG_W-1:0]    i_column_index,
    input  wire logic [srcc_pkg::VAL_W-1:0]    i_entry_value,
    input  wire logic [srcc_pkg::RIDX_W-1:0]   i_read_index,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [srcc_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [srcc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_status,
    output logic [srcc_pkg::CNT_W-1:0]         o_pointer_value,
    output logic [srcc_pkg::CFG_W-1:0]         o_row_out,
    output logic [srcc_pkg::CFG_W-1:0]         o_column_out,
    output logic [srcc_pkg::VAL_W-1:0]         o_value_out,
    output logic [srcc_pkg::CNT_W-1:0]         o_entry_total
);

    // latched item
    logic [srcc_pkg::ACT_W-1:0]  r_act;
    logic [srcc_pkg::ROW_W-1:0]  r_row;
    logic [srcc_pkg::CFG_W-1:0]  r_col;
    logic [srcc_pkg::VAL_W-1:0]  r_val;
    logic [srcc_pkg::RIDX_W-1:0] r_ridx;

    logic [srcc_pkg::CFG_W-1:0]  r_ncols, r_nrows;
    logic                        r_off;
    logic [srcc_pkg::CNT_W-1:0]  r_stored;
    logic                        r_built;
    logic [2:0]                  r_status;

    logic [srcc_pkg::CFG_W-1:0]  ncols, nrows, c0;
    logic [2:0]                  chk;

    logic                        r_pfx_v;
    logic [srcc_pkg::SWP_W-1:0]  r_pfx_k;
    logic [srcc_pkg::CNT_W-1:0]  r_cacc, r_racc;
    logic                        pfx_col, pfx_row;

    srcc_pkg::t_ent r_ent_q, r_tmp_q, r_slot_q;
    logic [srcc_pkg::CNT_W-1:0]  r_ccnt_q, r_rcnt_q, r_cs_q, r_cn_q, r_rn_q;

    srcc_pkg::t_ent              ent_mem  [srcc_pkg::MAX_ENTRIES];
    srcc_pkg::t_ent              tmp_mem  [srcc_pkg::MAX_ENTRIES];
    srcc_pkg::t_ent              slot_mem [srcc_pkg::MAX_ENTRIES];
    logic [srcc_pkg::CNT_W-1:0]  ccnt_mem [srcc_pkg::MAX_COLUMNS];
    logic [srcc_pkg::CNT_W-1:0]  rcnt_mem [srcc_pkg::MAX_ROWS];
    logic [srcc_pkg::CNT_W-1:0]  cs_mem   [srcc_pkg::MAX_COLUMNS + 1];
    logic [srcc_pkg::CNT_W-1:0]  cn_mem   [srcc_pkg::MAX_COLUMNS];
    logic [srcc_pkg::CNT_W-1:0]  rn_mem   [srcc_pkg::MAX_ROWS];

    logic [srcc_pkg::COL_W-1:0]  ccnt_ra, ccnt_wa, cn_ra, cn_wa;
    logic [srcc_pkg::ROW_W-1:0]  rcnt_ra, rcnt_wa, rn_ra, rn_wa;
    logic [srcc_pkg::CNT_W-1:0]  ccnt_wd, rcnt_wd, cn_wd, rn_wd;
    logic [srcc_pkg::CS_W-1:0]   cs_wa;
    logic                        cnt_we, cs_we, cn_we, rn_we;

    assign o_cfg_ready = 1'b1;

    // saturate register values into range
    always_comb begin
        if (r_ncols == '0)
            ncols = srcc_pkg::CFG_W'(1);
        else if (r_ncols > srcc_pkg::CFG_W'(srcc_pkg::MAX_COLUMNS))
            ncols = srcc_pkg::CFG_W'(srcc_pkg::MAX_COLUMNS);
        else
            ncols = r_ncols;
        if (r_nrows == '0)
            nrows = srcc_pkg::CFG_W'(1);
        else if (r_nrows > srcc_pkg::CFG_W'(srcc_pkg::MAX_ROWS))
            nrows = srcc_pkg::CFG_W'(srcc_pkg::MAX_ROWS);
        else
            nrows = r_nrows;
    end

    assign c0 = r_col - srcc_pkg::CFG_W'(1);

    always_comb begin
        chk = srcc_pkg::ST_OK;
        case (r_act)
            srcc_pkg::ACT_LOAD: begin
                if (r_built)
                    chk = srcc_pkg::ST_BUILT;
                else if (r_col == '0 || r_col > ncols)
                    chk = srcc_pkg::ST_BAD_COL;
                else if (srcc_pkg::CFG_W'(r_row) >= nrows)
                    chk = srcc_pkg::ST_BAD_ROW;
                else if (r_stored >= srcc_pkg::CNT_W'(srcc_pkg::MAX_ENTRIES))
                    chk = srcc_pkg::ST_FULL;
            end
            srcc_pkg::ACT_RPTR: begin
                if (!r_built)
                    chk = srcc_pkg::ST_NOT_BUILT;
                else if (srcc_pkg::CNT_W'(r_ridx) > srcc_pkg::CNT_W'(ncols))
                    chk = srcc_pkg::ST_BAD_IDX;
            end
            srcc_pkg::ACT_RSLOT: begin
                if (!r_built)
                    chk = srcc_pkg::ST_NOT_BUILT;
                else if (srcc_pkg::CNT_W'(r_ridx) >= r_stored)
                    chk = srcc_pkg::ST_BAD_IDX;
            end
            default: chk = srcc_pkg::ST_OK;
        endcase
    end

    assign o_stat.act      = r_act;
    assign o_stat.ok       = (chk == srcc_pkg::ST_OK);
    assign o_stat.out_free = !o_out_valid || i_out_ready;
    assign o_stat.stored   = r_stored;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act  <= i_action;
            r_row  <= i_row_index;
            r_col  <= i_column_index;
            r_val  <= i_entry_value;
            r_ridx <= i_read_index;
        end
        if (i_cmd.eval)
            r_status <= chk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncols  <= srcc_pkg::CFG_W'(4096);
            r_nrows  <= srcc_pkg::CFG_W'(4096);
            r_off    <= 1'b0;
            r_stored <= '0;
            r_built  <= 1'b0;
            r_pfx_v  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    srcc_pkg::CFG_NCOLS:  r_ncols <= i_cfg_data;
                    srcc_pkg::CFG_NROWS:  r_nrows <= i_cfg_data;
                    srcc_pkg::CFG_OFFSET: r_off   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_store) begin
                r_stored <= '0;
                r_built  <= 1'b0;
            end else if (i_cmd.ld_wr) begin
                r_stored <= r_stored + srcc_pkg::CNT_W'(1);
            end else if (i_cmd.set_built) begin
                r_built <= 1'b1;
            end
            r_pfx_v <= i_cmd.pfx_rd;
        end
    end

    // prefix sums over column and row counts
    assign pfx_col = r_pfx_v && (r_pfx_k < srcc_pkg::SWP_W'(srcc_pkg::MAX_COLUMNS));
    assign pfx_row = r_pfx_v && (r_pfx_k < srcc_pkg::SWP_W'(srcc_pkg::MAX_ROWS));

    always_ff @(posedge i_clk) begin
        r_pfx_k <= i_cmd.k;
        if (i_cmd.pfx_init) begin
            r_cacc <= '0;
            r_racc <= '0;
        end else begin
            if (pfx_col)
                r_cacc <= r_cacc + r_ccnt_q;
            if (pfx_row)
                r_racc <= r_racc + r_rcnt_q;
        end
    end

    // address and data selection
    always_comb begin
        cnt_we  = i_cmd.clr_wr || i_cmd.ld_wr;
        ccnt_wa = i_cmd.clr_wr ? srcc_pkg::COL_W'(i_cmd.k) : c0[srcc_pkg::COL_W-1:0];
        rcnt_wa = i_cmd.clr_wr ? srcc_pkg::ROW_W'(i_cmd.k) : r_row;
        ccnt_wd = i_cmd.clr_wr ? '0 : r_ccnt_q + srcc_pkg::CNT_W'(1);
        rcnt_wd = i_cmd.clr_wr ? '0 : r_rcnt_q + srcc_pkg::CNT_W'(1);
        ccnt_ra = i_cmd.pfx_rd ? srcc_pkg::COL_W'(i_cmd.k) : c0[srcc_pkg::COL_W-1:0];
        rcnt_ra = i_cmd.pfx_rd ? srcc_pkg::ROW_W'(i_cmd.k) : r_row;

        cs_we = pfx_col || i_cmd.pfx_end;
        cs_wa = i_cmd.pfx_end ? srcc_pkg::CS_W'(srcc_pkg::MAX_COLUMNS)
                              : srcc_pkg::CS_W'(r_pfx_k);

        cn_we = pfx_col || i_cmd.cs_wr;
        cn_wa = pfx_col ? srcc_pkg::COL_W'(r_pfx_k) : r_tmp_q.col;
        cn_wd = pfx_col ? r_cacc : r_cn_q + srcc_pkg::CNT_W'(1);
        cn_ra = r_tmp_q.col;

        rn_we = pfx_row || i_cmd.rs_wr;
        rn_wa = pfx_row ? srcc_pkg::ROW_W'(r_pfx_k) : r_ent_q.row;
        rn_wd = pfx_row ? r_racc : r_rn_q + srcc_pkg::CNT_W'(1);
        rn_ra = r_ent_q.row;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we)
            ccnt_mem[ccnt_wa] <= ccnt_wd;
        if (i_cmd.ld_rd || (i_cmd.pfx_rd &&
                i_cmd.k < srcc_pkg::SWP_W'(srcc_pkg::MAX_COLUMNS)))
            r_ccnt_q <= ccnt_mem[ccnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we)
            rcnt_mem[rcnt_wa] <= rcnt_wd;
        if (i_cmd.ld_rd || (i_cmd.pfx_rd &&
                i_cmd.k < srcc_pkg::SWP_W'(srcc_pkg::MAX_ROWS)))
            r_rcnt_q <= rcnt_mem[rcnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cs_we)
            cs_mem[cs_wa] <= r_cacc;
        if (i_cmd.ptr_rd)
            r_cs_q <= cs_mem[srcc_pkg::CS_W'(r_ridx)];
    end

    always_ff @(posedge i_clk) begin
        if (cn_we)
            cn_mem[cn_wa] <= cn_wd;
        if (i_cmd.cs_rd_nxt)
            r_cn_q <= cn_mem[cn_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rn_we)
            rn_mem[rn_wa] <= rn_wd;
        if (i_cmd.rs_rd_nxt)
            r_rn_q <= rn_mem[rn_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr)
            ent_mem[r_stored[srcc_pkg::ENT_W-1:0]] <= '{row: r_row,
                col: c0[srcc_pkg::COL_W-1:0], value: r_val};
        if (i_cmd.rs_rd_ent)
            r_ent_q <= ent_mem[i_cmd.i];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rs_wr)
            tmp_mem[r_rn_q[srcc_pkg::ENT_W-1:0]] <= r_ent_q;
        if (i_cmd.cs_rd_tmp)
            r_tmp_q <= tmp_mem[i_cmd.i];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cs_wr)
            slot_mem[r_cn_q[srcc_pkg::ENT_W-1:0]] <= r_tmp_q;
        if (i_cmd.slot_rd)
            r_slot_q <= slot_mem[r_ridx[srcc_pkg::ENT_W-1:0]];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status        <= r_status;
            o_pointer_value <= '0;
            o_row_out       <= '0;
            o_column_out    <= '0;
            o_value_out     <= '0;
            o_entry_total   <= '0;
            if (r_act == srcc_pkg::ACT_RPTR && r_status == srcc_pkg::ST_OK)
                o_pointer_value <= r_cs_q + srcc_pkg::CNT_W'(r_off);
            if (r_act == srcc_pkg::ACT_RSLOT && r_status == srcc_pkg::ST_OK) begin
                o_row_out    <= srcc_pkg::CFG_W'(r_slot_q.row) + srcc_pkg::CFG_W'(r_off);
                o_column_out <= srcc_pkg::CFG_W'(r_slot_q.col) + srcc_pkg::CFG_W'(r_off);
                o_value_out  <= r_slot_q.value;
            end
            if (r_act == srcc_pkg::ACT_BUILD)
                o_entry_total <= r_stored;
        end
    end

endmodule
`default_nettype wire

/* rtl/sparse_rows_to_compressed_column_top.sv */
`default_nettype none
// per item: check, action, result register; load reads then writes the counters and the entry
// read pointer or slot: one memory read; clear: sweep over the column and row counters
// build: prefix sweep, then two scatter passes (by row into staging, then by column into the
//   slots), each reading an entry, reading its next position, then writing it
// one item at a time; the next item is taken as soon as its result is in the output register
// reset: synchronous, active low; afterwards a sweep zeroes the counters, no item taken
module sparse_rows_to_compressed_column_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item input
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [srcc_pkg::ACT_W-1:0]    i_action,
    input  wire logic [srcc_pkg::ROW_W-1:0]    i_row_index,
    input  wire logic [srcc_pkg::CFG_W-1:0]    i_column_index,
    input  wire logic [srcc_pkg::VAL_W-1:0]    i_entry_value,
    input  wire logic [srcc_pkg::RIDX_W-1:0]   i_read_index,
    // register writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [srcc_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [srcc_pkg::CFG_W-1:0]    i_cfg_data,
    // result output
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_status,
    output logic [srcc_pkg::CNT_W-1:0]         o_pointer_value,
    output logic [srcc_pkg::CFG_W-1:0]         o_row_out,
    output logic [srcc_pkg::CFG_W-1:0]         o_column_out,
    output logic [srcc_pkg::VAL_W-1:0]         o_value_out,
    output logic [srcc_pkg::CNT_W-1:0]         o_entry_total
);

    // commands from the sequencer, status back from the datapath
    srcc_pkg::t_cmd  cmd;
    srcc_pkg::t_stat stat;

    // sequencer: clear sweep, load, prefix and scatter passes, reads
    srcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: entry, staging and slot memories, counters, pointers, result register
    srcc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_action),
        .i_row_index     (i_row_index),
        .i_column_index  (i_column_index),
        .i_entry_value   (i_entry_value),
        .i_read_index    (i_read_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_pointer_value (o_pointer_value),
        .o_row_out       (o_row_out),
        .o_column_out    (o_column_out),
        .o_value_out     (o_value_out),
        .o_entry_total   (o_entry_total)
    );

endmodule
`default_nettype wire

/* tb/sv/tb_sparse_rows_to_compressed_column_top.sv */
`timescale 1ns / 1ps

module tb_sparse_rows_to_compressed_column_top;

    typedef struct {
        logic [srcc_pkg::ACT_W-1:0]  act;
        logic [srcc_pkg::ROW_W-1:0]  row;
        logic [srcc_pkg::CFG_W-1:0]  col;
        logic [srcc_pkg::VAL_W-1:0]  val;
        logic [srcc_pkg::RIDX_W-1:0] ridx;
    } t_entry_item;

    typedef struct {
        logic [2:0]                 status;
        logic [srcc_pkg::CNT_W-1:0] ptr;
        logic [srcc_pkg::CFG_W-1:0] row_out;
        logic [srcc_pkg::CFG_W-1:0] col_out;
        logic [srcc_pkg::VAL_W-1:0] val_out;
        logic [srcc_pkg::CNT_W-1:0] total;
    } t_csc_result;

    // clock, reset and block inputs, all known from time zero
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic [srcc_pkg::ACT_W-1:0]    in_action = '0;
    logic [srcc_pkg::ROW_W-1:0]    in_row = '0;
    logic [srcc_pkg::CFG_W-1:0]    in_col = '0;
    logic [srcc_pkg::VAL_W-1:0]    in_val = '0;
    logic [srcc_pkg::RIDX_W-1:0]   in_ridx = '0;
    logic                          cfg_valid = 1'b0;
    logic [srcc_pkg::CIDX_W-1:0]   cfg_index = '0;
    logic [srcc_pkg::CFG_W-1:0]    cfg_data = '0;
    logic                          out_ready = 1'b0;

    logic                          o_in_ready, o_cfg_ready, o_out_valid;
    logic [2:0]                    o_status;
    logic [srcc_pkg::CNT_W-1:0]    o_pointer_value, o_entry_total;
    logic [srcc_pkg::CFG_W-1:0]    o_row_out, o_column_out;
    logic [srcc_pkg::VAL_W-1:0]    o_value_out;

    sparse_rows_to_compressed_column_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_action(in_action), .i_row_index(in_row), .i_column_index(in_col),
        .i_entry_value(in_val), .i_read_index(in_ridx),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_status(o_status), .o_pointer_value(o_pointer_value),
        .o_row_out(o_row_out), .o_column_out(o_column_out),
        .o_value_out(o_value_out), .o_entry_total(o_entry_total)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // generous ceiling: many clear and build sweeps plus receiver stalls
    initial begin
        #80_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor: own copy of registers, entry store and slot store
    // ---------------------------------------------------------------
    logic [srcc_pkg::CFG_W-1:0]  reg_ncols = 13'd4096;
    logic [srcc_pkg::CFG_W-1:0]  reg_nrows = 13'd4096;
    logic                        reg_offset = 1'b0;

    logic [srcc_pkg::ROW_W-1:0]  ent_row [srcc_pkg::MAX_ENTRIES];
    logic [srcc_pkg::COL_W-1:0]  ent_col [srcc_pkg::MAX_ENTRIES];
    logic [srcc_pkg::VAL_W-1:0]  ent_val [srcc_pkg::MAX_ENTRIES];
    logic [srcc_pkg::ROW_W-1:0]  slot_row [srcc_pkg::MAX_ENTRIES];
    logic [srcc_pkg::COL_W-1:0]  slot_col [srcc_pkg::MAX_ENTRIES];
    logic [srcc_pkg::VAL_W-1:0]  slot_val [srcc_pkg::MAX_ENTRIES];
    int                          col_count [srcc_pkg::MAX_COLUMNS];
    int                          col_start [srcc_pkg::MAX_COLUMNS+1];
    int                          col_fill [srcc_pkg::MAX_COLUMNS];
    int                          row_pos [srcc_pkg::MAX_ROWS+1];
    int                          row_order [srcc_pkg::MAX_ENTRIES];
    int                          n_stored = 0;
    bit                          is_built = 0;

    function automatic int clamp_reg(logic [srcc_pkg::CFG_W-1:0] v, int hi);
        if (v == 0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // prefix sum of column counts, then a stable scatter by ascending row
    function automatic void build_columns();
        int acc;
        int e;
        int s;
        acc = 0;
        for (int c = 0; c < srcc_pkg::MAX_COLUMNS; c++) begin
            col_start[c] = acc;
            acc += col_count[c];
            col_fill[c] = 0;
        end
        col_start[srcc_pkg::MAX_COLUMNS] = acc;
        for (int r = 0; r <= srcc_pkg::MAX_ROWS; r++) row_pos[r] = 0;
        for (int i = 0; i < n_stored; i++) row_pos[ent_row[i] + 1]++;
        for (int r = 0; r < srcc_pkg::MAX_ROWS; r++) row_pos[r+1] += row_pos[r];
        for (int i = 0; i < n_stored; i++) begin
            row_order[row_pos[ent_row[i]]] = i;
            row_pos[ent_row[i]]++;
        end
        for (int i = 0; i < n_stored; i++) begin
            e = row_order[i];
            s = col_start[ent_col[e]] + col_fill[ent_col[e]];
            col_fill[ent_col[e]]++;
            slot_row[s] = ent_row[e];
            slot_col[s] = ent_col[e];
            slot_val[s] = ent_val[e];
        end
        is_built = 1;
    endfunction

    function automatic t_csc_result predict_csc(t_entry_item it);
        t_csc_result res;
        int ncols;
        int nrows;
        res = '{default: '0};
        ncols = clamp_reg(reg_ncols, srcc_pkg::MAX_COLUMNS);
        nrows = clamp_reg(reg_nrows, srcc_pkg::MAX_ROWS);
        case (it.act)
            srcc_pkg::ACT_CLEAR: begin
                n_stored = 0;
                for (int c = 0; c < srcc_pkg::MAX_COLUMNS; c++) col_count[c] = 0;
                is_built = 0;
            end
            srcc_pkg::ACT_LOAD: begin
                if (is_built) res.status = srcc_pkg::ST_BUILT;
                else if (it.col < 1 || it.col > ncols) res.status = srcc_pkg::ST_BAD_COL;
                else if (it.row >= nrows) res.status = srcc_pkg::ST_BAD_ROW;
                else if (n_stored >= srcc_pkg::MAX_ENTRIES) res.status = srcc_pkg::ST_FULL;
                else begin
                    ent_row[n_stored] = it.row;
                    ent_col[n_stored] = srcc_pkg::COL_W'(it.col - 1);
                    ent_val[n_stored] = it.val;
                    col_count[it.col - 1]++;
                    n_stored++;
                end
            end
            srcc_pkg::ACT_BUILD: begin
                build_columns();
                res.total = srcc_pkg::CNT_W'(n_stored);
            end
            srcc_pkg::ACT_RPTR: begin
                if (!is_built) res.status = srcc_pkg::ST_NOT_BUILT;
                else if (it.ridx > ncols) res.status = srcc_pkg::ST_BAD_IDX;
                else res.ptr = srcc_pkg::CNT_W'(col_start[it.ridx] + reg_offset);
            end
            srcc_pkg::ACT_RSLOT: begin
                if (!is_built) res.status = srcc_pkg::ST_NOT_BUILT;
                else if (it.ridx >= n_stored) res.status = srcc_pkg::ST_BAD_IDX;
                else begin
                    res.row_out = srcc_pkg::CFG_W'(slot_row[it.ridx]) + reg_offset;
                    res.col_out = srcc_pkg::CFG_W'(slot_col[it.ridx]) + reg_offset;
                    res.val_out = slot_val[it.ridx];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // sender: bursts of items separated by random gaps
    // ---------------------------------------------------------------
    t_csc_result expected_results[$];
    int          burst_left = 0;
    int          mismatches = 0;

    task automatic send_item(t_entry_item it, bit typed, t_csc_result typed_res);
        t_csc_result res;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid  <= 1'b1;
        in_action <= it.act;
        in_row    <= it.row;
        in_col    <= it.col;
        in_val    <= it.val;
        in_ridx   <= it.ridx;
        do @(posedge i_clk); while (!o_in_ready);
        res = predict_csc(it);
        expected_results.push_back(typed ? typed_res : res);
        burst_left--;
        // lower valid only when a gap follows
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    task automatic send_plain(logic [srcc_pkg::ACT_W-1:0] act,
                              logic [srcc_pkg::ROW_W-1:0] row,
                              logic [srcc_pkg::CFG_W-1:0] col,
                              logic [srcc_pkg::VAL_W-1:0] val,
                              logic [srcc_pkg::RIDX_W-1:0] ridx);
        t_entry_item it;
        it = '{act, row, col, val, ridx};
        send_item(it, 0, '{default: '0});
    endtask

    // registers are written only with nothing in flight
    task automatic write_reg(logic [srcc_pkg::CIDX_W-1:0] idx,
                             logic [srcc_pkg::CFG_W-1:0] data);
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            srcc_pkg::CFG_NCOLS:  reg_ncols = data;
            srcc_pkg::CFG_NROWS:  reg_nrows = data;
            srcc_pkg::CFG_OFFSET: reg_offset = data[0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // receiver: stall pattern of its own plus one long hold-off
    // ---------------------------------------------------------------
    bit hold_off = 0;
    bit rand_started = 0;
    int stall_mode = 0;
    int rx_cycle = 0;

    function automatic void report(string what, t_csc_result exp);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: exp st=%0d ptr=%0d row=%0d col=%0d val=%h tot=%0d | got st=%0d ptr=%0d row=%0d col=%0d val=%h tot=%0d",
                     what, exp.status, exp.ptr, exp.row_out, exp.col_out, exp.val_out,
                     exp.total, o_status, o_pointer_value, o_row_out, o_column_out,
                     o_value_out, o_entry_total);
    endfunction

    always @(posedge i_clk) begin
        t_csc_result exp;
        if (o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected item", '{default: '0});
            end else begin
                exp = expected_results.pop_front();
                if (o_status !== exp.status || o_pointer_value !== exp.ptr ||
                    o_row_out !== exp.row_out || o_column_out !== exp.col_out ||
                    o_value_out !== exp.val_out || o_entry_total !== exp.total)
                    report("field", exp);
            end
        end
        rx_cycle++;
        if (rx_cycle % 97 == 0) stall_mode = $urandom_range(0, 2);
        if (hold_off) out_ready <= 1'b0;
        else case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (rx_cycle % 4 == 0);
        endcase
    end

    // long receiver hold-off, started while a load is offered with the output
    // register occupied, so the block parks that load and stalls its input
    initial begin
        wait (rand_started);
        repeat (200) @(posedge i_clk);
        do @(posedge i_clk);
        while (!(o_out_valid && in_valid && o_in_ready && in_action == srcc_pkg::ACT_LOAD));
        hold_off = 1;
        repeat (600) @(posedge i_clk);
        hold_off = 0;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    typedef struct {
        t_entry_item it;
        bit          typed;
        t_csc_result res;
    } t_table_row;

    t_table_row directed[$];

    function automatic void add_row(logic [srcc_pkg::ACT_W-1:0] act,
                                    logic [srcc_pkg::ROW_W-1:0] row,
                                    logic [srcc_pkg::CFG_W-1:0] col,
                                    logic [srcc_pkg::VAL_W-1:0] val,
                                    logic [srcc_pkg::RIDX_W-1:0] ridx, bit typed,
                                    logic [2:0] st, logic [srcc_pkg::CNT_W-1:0] ptr,
                                    logic [srcc_pkg::CNT_W-1:0] total);
        t_table_row r;
        r.it = '{act, row, col, val, ridx};
        r.typed = typed;
        r.res = '{status: st, ptr: ptr, total: total, default: '0};
        directed.push_back(r);
    endfunction

    initial begin
        int ncols_opts[6] = '{4096, 1, 0, 8191, 16, 3000};
        int nrows_opts[6] = '{4096, 7, 8191, 0, 4096, 100};
        int nc;
        int nr;
        int k;
        int j;
        int csel;
        logic [srcc_pkg::CFG_W-1:0] col;
        logic [srcc_pkg::ROW_W-1:0] row;
        logic [srcc_pkg::ACT_W-1:0] act;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: 4096 columns, 4096 rows, offset 0
        add_row(srcc_pkg::ACT_RSLOT, 0, 0, 0, 0, 1, srcc_pkg::ST_NOT_BUILT, 0, 0);
        add_row(srcc_pkg::ACT_RPTR, 0, 0, 0, 0, 1, srcc_pkg::ST_NOT_BUILT, 0, 0);
        add_row(srcc_pkg::ACT_LOAD, 0, 0, 0, 0, 1, srcc_pkg::ST_BAD_COL, 0, 0);
        add_row(srcc_pkg::ACT_LOAD, 0, 4097, 0, 0, 1, srcc_pkg::ST_BAD_COL, 0, 0);
        add_row(srcc_pkg::ACT_LOAD, 0, 8191, 0, 0, 1, srcc_pkg::ST_BAD_COL, 0, 0);
        add_row(srcc_pkg::ACT_LOAD, 4095, 4096, '1, 0, 1, srcc_pkg::ST_OK, 0, 0);
        add_row(srcc_pkg::ACT_LOAD, 5, 1, 64'd123, 0, 1, srcc_pkg::ST_OK, 0, 0);
        add_row(srcc_pkg::ACT_LOAD, 0, 1, 64'd0, 0, 1, srcc_pkg::ST_OK, 0, 0);
        add_row(srcc_pkg::ACT_LOAD, 2, 1, 64'hdead_beef_0123_4567, 0, 1,
                srcc_pkg::ST_OK, 0, 0);
        add_row(srcc_pkg::ACT_LOAD, 2, 1, 64'h8000_0000_0000_0001, 0, 1,
                srcc_pkg::ST_OK, 0, 0);
        add_row(3'd5, '1, '1, '1, '1, 1, srcc_pkg::ST_OK, 0, 0);
        add_row(3'd6, 0, 0, 0, 0, 1, srcc_pkg::ST_OK, 0, 0);
        add_row(3'd7, 0, 0, 0, 0, 1, srcc_pkg::ST_OK, 0, 0);
        add_row(srcc_pkg::ACT_BUILD, 0, 0, 0, 0, 1, srcc_pkg::ST_OK, 0, 5);
        add_row(srcc_pkg::ACT_LOAD, 1, 1, 0, 0, 1, srcc_pkg::ST_BUILT, 0, 0);
        add_row(srcc_pkg::ACT_RPTR, 0, 0, 0, 0, 1, srcc_pkg::ST_OK, 0, 0);
        add_row(srcc_pkg::ACT_RPTR, 0, 0, 0, 4096, 1, srcc_pkg::ST_OK, 5, 0);
        add_row(srcc_pkg::ACT_RPTR, 0, 0, 0, 4097, 1, srcc_pkg::ST_BAD_IDX, 0, 0);
        for (int s = 0; s < 5; s++)
            add_row(srcc_pkg::ACT_RSLOT, 0, 0, 0, srcc_pkg::RIDX_W'(s), 0, 0, 0, 0);
        add_row(srcc_pkg::ACT_RSLOT, 0, 0, 0, 16'hffff, 1, srcc_pkg::ST_BAD_IDX, 0, 0);
        add_row(srcc_pkg::ACT_BUILD, 0, 0, 0, 0, 1, srcc_pkg::ST_OK, 0, 5);
        add_row(srcc_pkg::ACT_CLEAR, 0, 0, 0, 0, 1, srcc_pkg::ST_OK, 0, 0);
        add_row(srcc_pkg::ACT_RSLOT, 0, 0, 0, 0, 1, srcc_pkg::ST_NOT_BUILT, 0, 0);
        foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].res);

        rand_started = 1;
        for (int phase = 0; phase < 46; phase++) begin
            write_reg(srcc_pkg::CFG_NCOLS, srcc_pkg::CFG_W'(ncols_opts[phase % 6]));
            write_reg(srcc_pkg::CFG_NROWS, srcc_pkg::CFG_W'(nrows_opts[(phase / 2) % 6]));
            write_reg(srcc_pkg::CFG_OFFSET, srcc_pkg::CFG_W'(phase % 2));
            nc = clamp_reg(reg_ncols, srcc_pkg::MAX_COLUMNS);
            nr = clamp_reg(reg_nrows, srcc_pkg::MAX_ROWS);
            if ($urandom_range(0, 3) == 0)
                send_plain(srcc_pkg::ACT_RSLOT, 0, 0, 0, srcc_pkg::RIDX_W'($urandom));
            send_plain(srcc_pkg::ACT_CLEAR, srcc_pkg::ROW_W'($urandom),
                       srcc_pkg::CFG_W'($urandom), {$urandom, $urandom},
                       srcc_pkg::RIDX_W'($urandom));
            k = $urandom_range(0, 24);
            for (int n = 0; n < k; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    csel = $urandom_range(0, 1) ? ((nc < 8) ? nc : 8) : nc;
                    col = srcc_pkg::CFG_W'($urandom_range(1, csel));
                    row = srcc_pkg::ROW_W'($urandom_range(0,
                          $urandom_range(0, 1) ? nr - 1 : ((nr < 6) ? nr - 1 : 5)));
                end else begin
                    col = srcc_pkg::CFG_W'($urandom);
                    row = srcc_pkg::ROW_W'($urandom);
                end
                send_plain(srcc_pkg::ACT_LOAD, row, col, {$urandom, $urandom},
                           srcc_pkg::RIDX_W'($urandom));
            end
            send_plain(srcc_pkg::ACT_BUILD, 0, 0, 0, 0);
            j = $urandom_range(4, 14);
            for (int n = 0; n < j; n++) begin
                csel = $urandom_range(0, 9);
                if (csel < 5 && n_stored > 0)
                    send_plain(srcc_pkg::ACT_RSLOT, 0, 0, 0,
                               srcc_pkg::RIDX_W'($urandom_range(0, n_stored - 1)));
                else if (csel < 8)
                    send_plain(srcc_pkg::ACT_RPTR, 0, 0, 0,
                               srcc_pkg::RIDX_W'($urandom_range(0, nc)));
                else begin
                    act = ($urandom_range(0, 7) == 0) ? srcc_pkg::ACT_BUILD
                                                     : srcc_pkg::ACT_W'($urandom);
                    send_plain(act, srcc_pkg::ROW_W'($urandom), srcc_pkg::CFG_W'($urandom),
                               {$urandom, $urandom}, srcc_pkg::RIDX_W'($urandom));
                end
            end
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
